[src/vmf_pkg.sv]
// vmf_pkg: widths and reset constants shared by the vector mode finder
`default_nettype none

package vmf_pkg;

  localparam int SAMPLE_W = 8;
  localparam int COUNT_W  = 11;
  localparam int LEN_W    = 11;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [LEN_W-1:0]    len_t;

endpackage

`default_nettype wire

[src/vmf_ram.sv]
// vmf_ram: generic single write port, single read port ram with registered read
`default_nettype none

module vmf_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/vector_mode_finder.sv]
// vector_mode_finder: top level, streaming histogram mode finder
`default_nettype none

// Takes one sample per cycle while sample_stall is low, no gaps needed between
// items, and reports the mode of each vector of vector_length samples (0 acts
// as 1) via the read-modify-write stage and the output register once the
// vector's last sample is accepted. Bin counts live in a ram with a registered
// read: a sample's bin is read on the cycle it is accepted and written back on
// the next, and a repeated bin on consecutive samples is forwarded from the last
// write. Per-bin valid flags clear the whole histogram at once at the end of each
// vector, so no clearing pass is needed after reset or between vectors. The best
// value's count is kept in a register. An output register plus one skid entry
// hold finished results; sample_stall rises only when mode_stall keeps them full.

module vector_mode_finder
  import vmf_pkg::*;
#(
  parameter int NUM_BINS = 256
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_valid,
  output      logic           cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_data,
  input  wire logic           sample_valid,
  output      logic           sample_stall,
  input  wire logic [SAMPLE_W-1:0] sample,
  output      logic           mode_valid,
  input  wire logic           mode_stall,
  output      logic [SAMPLE_W-1:0] mode_value
);

  localparam int MAX_BINS = 2 ** SAMPLE_W;
  localparam int BINS     = (NUM_BINS < MAX_BINS) ? NUM_BINS : MAX_BINS;
  localparam int AW       = $clog2(BINS);
  localparam logic [SAMPLE_W:0] BIN_LIMIT = (SAMPLE_W + 1)'(BINS);

  len_t    vector_length;
  len_t    position;
  len_t    pos_next;
  len_t    len_eff;
  sample_t best;
  count_t  best_count;

  logic         s1_valid;
  sample_t      s1_sample;
  logic [AW-1:0] s1_addr;
  logic         s1_in_range;
  logic         s1_last;
  count_t       rd_count;
  count_t       cur_count;
  count_t       new_count;
  sample_t      best_next;
  count_t       best_count_next;
  logic         fwd_hit;

  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  count_t        fwd_data;

  logic [BINS-1:0] bin_valid;

  logic    skid_valid;
  sample_t skid_value;
  logic    pop;
  logic    push;
  logic [1:0] held;
  logic    accept;
  logic    wr_en;

  assign cfg_ready = 1'b1;

  // admission: worst case room for the item now entering
  assign pop          = mode_valid && !mode_stall;
  assign held         = 2'(mode_valid) + 2'(skid_valid) + 2'(s1_valid) - 2'(pop);
  assign sample_stall = (held >= 2'd2);
  assign accept       = sample_valid && !sample_stall;

  vmf_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(BINS)
  ) u_bins (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(s1_addr),
    .wr_data(new_count),
    .rd_en  (accept),
    .rd_addr(sample[AW-1:0]),
    .rd_data(rd_count)
  );

  // read-modify-write stage
  always_comb begin
    s1_addr     = s1_sample[AW-1:0];
    s1_in_range = ({1'b0, s1_sample} < BIN_LIMIT);
    fwd_hit     = fwd_valid && (fwd_addr == s1_addr);
    if (fwd_hit) begin
      cur_count = fwd_data;
    end else if (bin_valid[s1_addr]) begin
      cur_count = rd_count;
    end else begin
      cur_count = '0;
    end
    new_count = cur_count + COUNT_W'(1);
    wr_en     = s1_valid && s1_in_range;

    best_next       = best;
    best_count_next = best_count;
    if (s1_in_range) begin
      if (s1_sample == best) begin
        best_count_next = new_count;
      end else if (best_count < new_count) begin
        best_next       = s1_sample;
        best_count_next = new_count;
      end
    end

    len_eff  = (vector_length == '0) ? LEN_W'(1) : vector_length;
    pos_next = position + LEN_W'(1);
    s1_last  = (pos_next >= len_eff) || (pos_next == '0);
    push     = s1_valid && s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= LEN_RESET;
      position      <= '0;
      best          <= '0;
      best_count    <= '0;
      s1_valid      <= 1'b0;
      fwd_valid     <= 1'b0;
      bin_valid     <= '0;
      mode_valid    <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vector_length <= cfg_data;
      end

      s1_valid <= accept;
      if (accept) begin
        s1_sample <= sample;
      end

      fwd_valid <= wr_en && !s1_last;
      fwd_addr  <= s1_addr;
      fwd_data  <= new_count;

      if (s1_valid) begin
        if (s1_last) begin
          position   <= '0;
          best       <= '0;
          best_count <= '0;
          bin_valid  <= '0;
        end else begin
          position   <= pos_next;
          best       <= best_next;
          best_count <= best_count_next;
          if (s1_in_range) begin
            bin_valid[s1_addr] <= 1'b1;
          end
        end
      end

      // output register with one skid entry
      if (!mode_valid || pop) begin
        if (skid_valid) begin
          mode_value <= skid_value;
          skid_valid <= push;
          skid_value <= best_next;
        end else begin
          mode_valid <= push;
          mode_value <= best_next;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
        skid_value <= best_next;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> mode_valid)
    else $error("skid entry held while output register empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && skid_valid && mode_valid && !pop))
    else $error("result lost: output register and skid both full");

  a_fwd_implies_valid: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && fwd_hit) |-> bin_valid[s1_addr])
    else $error("forwarded count for a bin not marked valid");

  a_vector_restart: assert property (@(posedge clk) disable iff (rst)
    push |=> (position == '0) && (best == '0) && (best_count == '0))
    else $error("vector state not cleared after last sample");

endmodule

`default_nettype wire
